/* rtl/sab_pkg.sv */
// Shared constants, codes and types of the stacked arena block allocator.
`default_nettype none

package sab_pkg;

    localparam int NUM_BLOCKS    = 16;
    localparam int PAYLOAD_BYTES = 512;
    localparam int ALIGN_BYTES   = 16;
    localparam int HEADER_BYTES  = 32;

    localparam int BLOCK_SIZE = ((HEADER_BYTES + PAYLOAD_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                * ALIGN_BYTES;
    localparam int DATA_START = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int MAX_SZ     = BLOCK_SIZE - DATA_START;

    localparam int OP_W    = 2;
    localparam int BYTES_W = 10;
    localparam int ADDR_W  = 14;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;

    localparam int BLK_W   = $clog2(NUM_BLOCKS + 1);
    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int FILL_W  = $clog2(BLOCK_SIZE + 1);
    localparam int ALIGN_W = $clog2(ALIGN_BYTES);
    localparam int SZ_W    = $clog2((((1 << BYTES_W) - 1 + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                    * ALIGN_BYTES + 1);
    localparam int SUM_W   = ((FILL_W > SZ_W) ? FILL_W : SZ_W) + 1;
    localparam int PROD_W  = BLK_W + FILL_W;

    localparam logic [BLK_W-1:0] NONE = BLK_W'(NUM_BLOCKS);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOARENA = 2'd2;
    localparam logic [STAT_W-1:0] STAT_TOOBIG  = 2'd3;

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [FILL_W-1:0] off;
        logic [SZ_W-1:0]   add;
    } alu_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SUM_W-1:0]  sum;
        logic              over;
    } alu_out_t;

    function automatic logic blk_valid(input logic [BLK_W-1:0] b);
        return b < NONE;
    endfunction

endpackage

`default_nettype wire

/* rtl/sab_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sab_alu.sv */
// Shared address and fill arithmetic unit of the allocator.
`default_nettype none

module sab_alu (
    input  wire sab_pkg::alu_in_t  op,
    output sab_pkg::alu_out_t      res
);

    logic [sab_pkg::PROD_W-1:0] addr_full;

    always_comb
    begin
        addr_full = sab_pkg::PROD_W'(op.blk) * sab_pkg::PROD_W'(sab_pkg::BLOCK_SIZE)
                    + sab_pkg::PROD_W'(op.off);
        res.addr  = addr_full[sab_pkg::ADDR_W-1:0];
        res.sum   = sab_pkg::SUM_W'(op.off) + sab_pkg::SUM_W'(op.add);
        res.over  = res.sum > sab_pkg::SUM_W'(sab_pkg::BLOCK_SIZE);
    end

endmodule

`default_nettype wire

/* rtl/stacked_arena_block_allocator.sv */
// Top level: sequencer of the stacked arena block allocator.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s       | in        | s_tvalid/s_tready | s_tuser: opcode; s_tdata: alloc_bytes
//  m       | out       | m_tvalid/m_tready | m_tdata: address, status
//
// One transaction at a time; s_tready is high only while the sequencer is idle.
// Allocate that fits: decode, fill check, done; one that chains a block adds take, init, link.
// Push: decode, take, init, done. Pop: decode, parent fetch, one link read per parent block.
// All block links and fill offsets sit in single-port-read RAMs, one access per cycle.
// A finished result waits in the output register; the next transaction is taken meanwhile.
// Reset clears the control registers only; the block RAMs need no clearing.
`default_nettype none

module stacked_arena_block_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [sab_pkg::IN_W-1:0]    s_tdata,   // [9:0] alloc_bytes
    input  wire logic [sab_pkg::OP_W-1:0]    s_tuser,   // [1:0] opcode
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [sab_pkg::OUT_W-1:0]   m_tdata    // [13:0] address, [15:14] status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC,
        ST_A_CHK,
        ST_TAKE,
        ST_TK_POP,
        ST_TK_INIT,
        ST_TK_LINK,
        ST_P_PAR,
        ST_P_WALK,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [sab_pkg::OP_W-1:0]        op_reg, op_next;
    logic [sab_pkg::SZ_W-1:0]        sz_reg, sz_next;
    logic [sab_pkg::BLK_W-1:0]       free_head_reg, free_head_next;
    logic [sab_pkg::BLK_W-1:0]       top_reg, top_next;
    logic [sab_pkg::BLK_W-1:0]       cur_reg, cur_next;
    logic [sab_pkg::BLK_W-1:0]       fresh_reg, fresh_next;
    logic [sab_pkg::BLK_W-1:0]       nb_reg, nb_next;
    logic [sab_pkg::BLK_W-1:0]       walk_reg, walk_next;
    logic [sab_pkg::IDX_W-1:0]       cnt_reg, cnt_next;
    logic [sab_pkg::ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [sab_pkg::STAT_W-1:0]      res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic [sab_pkg::OUT_W-1:0]       m_data_reg, m_data_next;

    logic                            next_we, next_re;
    logic [sab_pkg::IDX_W-1:0]       next_wa, next_ra;
    logic [sab_pkg::BLK_W-1:0]       next_wd, next_rd;
    logic                            par_we, par_re;
    logic [sab_pkg::IDX_W-1:0]       par_wa, par_ra;
    logic [sab_pkg::BLK_W-1:0]       par_wd, par_rd;
    logic                            fill_we, fill_re;
    logic [sab_pkg::IDX_W-1:0]       fill_wa, fill_ra;
    logic [sab_pkg::FILL_W-1:0]      fill_wd, fill_rd;

    logic [sab_pkg::SZ_W-1:0]        sz_raw;
    logic [sab_pkg::BLK_W-1:0]       new_top;
    sab_pkg::alu_in_t                alu_op;
    sab_pkg::alu_out_t               alu_res;

    sab_ram #(.WIDTH(sab_pkg::BLK_W), .DEPTH(sab_pkg::NUM_BLOCKS)) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_en   (next_re),
        .rd_addr (next_ra),
        .rd_data (next_rd)
    );

    sab_ram #(.WIDTH(sab_pkg::BLK_W), .DEPTH(sab_pkg::NUM_BLOCKS)) u_parent_ram (
        .clk     (clk),
        .wr_en   (par_we),
        .wr_addr (par_wa),
        .wr_data (par_wd),
        .rd_en   (par_re),
        .rd_addr (par_ra),
        .rd_data (par_rd)
    );

    sab_ram #(.WIDTH(sab_pkg::FILL_W), .DEPTH(sab_pkg::NUM_BLOCKS)) u_fill_ram (
        .clk     (clk),
        .wr_en   (fill_we),
        .wr_addr (fill_wa),
        .wr_data (fill_wd),
        .rd_en   (fill_re),
        .rd_addr (fill_ra),
        .rd_data (fill_rd)
    );

    sab_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // round the request up to the alignment
    assign sz_raw  = (sab_pkg::SZ_W'(s_tdata[sab_pkg::BYTES_W-1:0])
                      + sab_pkg::SZ_W'(sab_pkg::ALIGN_BYTES - 1))
                     >> sab_pkg::ALIGN_W << sab_pkg::ALIGN_W;
    assign new_top = sab_pkg::blk_valid(par_rd) ? par_rd : sab_pkg::NONE;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sz_next         = sz_reg;
        free_head_next  = free_head_reg;
        top_next        = top_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        nb_next         = nb_reg;
        walk_next       = walk_reg;
        cnt_next        = cnt_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        next_we = 1'b0;
        next_wa = cur_reg[sab_pkg::IDX_W-1:0];
        next_wd = free_head_reg;
        next_re = 1'b0;
        next_ra = free_head_reg[sab_pkg::IDX_W-1:0];
        par_we  = 1'b0;
        par_wa  = nb_reg[sab_pkg::IDX_W-1:0];
        par_wd  = top_reg;
        par_re  = 1'b0;
        par_ra  = top_reg[sab_pkg::IDX_W-1:0];
        fill_we = 1'b0;
        fill_wa = cur_reg[sab_pkg::IDX_W-1:0];
        fill_wd = alu_res.sum[sab_pkg::FILL_W-1:0];
        fill_re = 1'b0;
        fill_ra = cur_reg[sab_pkg::IDX_W-1:0];

        alu_op.blk = cur_reg;
        alu_op.off = fill_rd;
        alu_op.add = sz_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = s_tuser;
                    sz_next         = sz_raw;
                    res_addr_next   = '0;
                    res_status_next = sab_pkg::STAT_OK;
                    state_next      = ST_DEC;
                end
            end
            ST_DEC:
            begin
                case (op_reg)
                    sab_pkg::OP_ALLOC:
                    begin
                        if (!sab_pkg::blk_valid(cur_reg) || !sab_pkg::blk_valid(top_reg))
                        begin
                            res_status_next = sab_pkg::STAT_NOARENA;
                            state_next      = ST_DONE;
                        end
                        else if (sz_reg > sab_pkg::SZ_W'(sab_pkg::MAX_SZ))
                        begin
                            res_status_next = sab_pkg::STAT_TOOBIG;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            fill_re    = 1'b1;
                            state_next = ST_A_CHK;
                        end
                    end
                    sab_pkg::OP_PUSH:
                    begin
                        state_next = ST_TAKE;
                    end
                    sab_pkg::OP_POP:
                    begin
                        if (!sab_pkg::blk_valid(top_reg) || !sab_pkg::blk_valid(cur_reg))
                        begin
                            res_status_next = sab_pkg::STAT_NOARENA;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            // hand the whole top chain to the free list, fetch the parent
                            next_we        = 1'b1;
                            free_head_next = top_reg;
                            par_re         = 1'b1;
                            state_next     = ST_P_PAR;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_A_CHK:
            begin
                if (alu_res.over)
                begin
                    state_next = ST_TAKE;
                end
                else
                begin
                    fill_we       = 1'b1;
                    res_addr_next = alu_res.addr;
                    state_next    = ST_DONE;
                end
            end
            ST_TAKE:
            begin
                if (sab_pkg::blk_valid(free_head_reg))
                begin
                    next_re    = 1'b1;
                    state_next = ST_TK_POP;
                end
                else if (fresh_reg < sab_pkg::NONE)
                begin
                    nb_next    = fresh_reg;
                    fresh_next = fresh_reg + sab_pkg::BLK_W'(1);
                    state_next = ST_TK_INIT;
                end
                else
                begin
                    res_status_next = sab_pkg::STAT_NOMEM;
                    state_next      = ST_DONE;
                end
            end
            ST_TK_POP:
            begin
                nb_next        = free_head_reg;
                free_head_next = next_rd;
                state_next     = ST_TK_INIT;
            end
            ST_TK_INIT:
            begin
                next_we    = 1'b1;
                next_wa    = nb_reg[sab_pkg::IDX_W-1:0];
                next_wd    = sab_pkg::NONE;
                fill_we    = 1'b1;
                fill_wa    = nb_reg[sab_pkg::IDX_W-1:0];
                alu_op.blk = nb_reg;
                alu_op.off = sab_pkg::FILL_W'(sab_pkg::DATA_START);
                if (op_reg == sab_pkg::OP_PUSH)
                begin
                    fill_wd    = sab_pkg::FILL_W'(sab_pkg::DATA_START);
                    par_we     = 1'b1;
                    top_next   = nb_reg;
                    cur_next   = nb_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    // a fresh block always fits a request that passed the size check
                    res_addr_next = alu_res.addr;
                    state_next    = ST_TK_LINK;
                end
            end
            ST_TK_LINK:
            begin
                next_we    = 1'b1;
                next_wd    = nb_reg;
                cur_next   = nb_reg;
                state_next = ST_DONE;
            end
            ST_P_PAR:
            begin
                top_next  = new_top;
                walk_next = new_top;
                cnt_next  = '0;
                if (sab_pkg::blk_valid(new_top))
                begin
                    next_re    = 1'b1;
                    next_ra    = new_top[sab_pkg::IDX_W-1:0];
                    state_next = ST_P_WALK;
                end
                else
                begin
                    cur_next   = sab_pkg::NONE;
                    state_next = ST_DONE;
                end
            end
            ST_P_WALK:
            begin
                // advance along the parent chain to its last block
                if (!sab_pkg::blk_valid(next_rd))
                begin
                    cur_next   = walk_reg;
                    state_next = ST_DONE;
                end
                else if (cnt_reg == sab_pkg::IDX_W'(sab_pkg::NUM_BLOCKS - 1))
                begin
                    cur_next   = next_rd;
                    state_next = ST_DONE;
                end
                else
                begin
                    walk_next = next_rd;
                    cnt_next  = cnt_reg + sab_pkg::IDX_W'(1);
                    next_re   = 1'b1;
                    next_ra   = next_rd[sab_pkg::IDX_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_data_next  = {res_status_reg, res_addr_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= sab_pkg::NONE;
            top_reg       <= sab_pkg::NONE;
            cur_reg       <= sab_pkg::NONE;
            fresh_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            top_reg       <= top_next;
            cur_reg       <= cur_next;
            fresh_reg     <= fresh_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sz_reg         <= sz_next;
        nb_reg         <= nb_next;
        walk_reg       <= walk_next;
        cnt_reg        <= cnt_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

endmodule

`default_nettype wire

/* rtl/sab_checker.sv */
// Port-level checks of the allocator, bound to the top level.
`default_nettype none

module sab_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [sab_pkg::OUT_W-1:0]   m_tdata
);

    // hold a result until it is taken
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

    a_m_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a transaction is in work");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[sab_pkg::OUT_W-1:sab_pkg::ADDR_W] != sab_pkg::STAT_OK)
        |-> (m_tdata[sab_pkg::ADDR_W-1:0] == '0))
        else $error("failed request carries an address");

endmodule

bind stacked_arena_block_allocator sab_checker u_sab_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
